// ===== src/ciss_pkg.sv =====
`default_nettype none

package ciss_pkg;

  // Search limits
  localparam int PATTERN_MAX = 16;
  localparam int TEXT_MAX    = 1048576;

  // Field widths fixed by the interface
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 5;
  localparam int START_W     = 20;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int PAT_BYTES   = 16;
  localparam int HALF_BYTES  = PAT_BYTES / 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // Derived sizes
  localparam int WIN_IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CNT_MAX     = TEXT_MAX + PATTERN_MAX;
  localparam int CNT_W       = $clog2(CNT_MAX + 1);
  localparam int START_LIMIT = (1 << START_W) - 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2
  } cfg_reg_e;

  // Fold ASCII upper case to lower case
  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/case_insensitive_substring_search_top.sv =====
// Case-insensitive substring search over a byte stream.
// Input stream: one text byte per request on s_axis_tdata, s_axis_tlast marks
// the last byte of a text. ASCII A-Z are folded to lower case on both the
// text and the pattern.
// Configuration: cfg_wr_en_i/cfg_index_i/cfg_wdata_i write the pattern bytes
// (indexes 0 and 1) and the pattern length (index 2). Write only while idle.
// Output stream: one request per text, issued for the byte marked last:
// m_axis_tdata bit 0 is match_found, bits 20:1 the zero-based start of the
// first match (0 when none). An empty pattern never matches.
// Throughput: one byte per cycle while no result waits on a stalled receiver; the
// window compare is a single parallel stage feeding the result register.
// Latency: the result is valid the cycle after the last byte is accepted.
// Reset clears the byte counter, the hit state, the result valid flag and all
// configuration registers. The window and the result payload are left as they
// are; a compare only looks at bytes taken in the current text.
// Stall: a pending result is held in the output register; s_axis_tready
// stays high while that register is empty or being read this cycle, and
// drops while a result waits on a stalled receiver.
`default_nettype none

module case_insensitive_substring_search_top
  import ciss_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // Configuration write port
  input  wire                        cfg_wr_en_i,
  input  wire [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire [CFG_W-1:0]            cfg_wdata_i,
  // Text input stream
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire [IN_TDATA_W-1:0]       s_axis_tdata,   // [7:0] text_byte
  input  wire                        s_axis_tlast,   // is_final
  // Result output stream
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [OUT_TDATA_W-1:0]     m_axis_tdata    // [0] match_found, [20:1] match_start
);

  // Pattern store, held folded
  logic [BYTE_W-1:0]  pat_q [PAT_BYTES];
  logic [LEN_W-1:0]   len_q;

  // Per-text search state
  logic [BYTE_W-1:0]  win_q [PATTERN_MAX];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               hit_q, hit_d;
  logic [START_W-1:0] hit_start_q, hit_start_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;
  logic [START_W-1:0] out_start_q, out_start_d;

  logic               accept;
  logic [BYTE_W-1:0]  win_new [PATTERN_MAX];
  logic [LEN_W-1:0]   eff_len;
  logic [CNT_W:0]     pos1;
  logic [CNT_W:0]     start_now;
  logic               match_now;
  logic               hit_now;

  // Take a byte whenever the result register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration writes, folding the pattern on the way in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAT_BYTES; i++) begin
        pat_q[i] <= '0;
      end
      len_q <= '0;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PAT_LO: begin
          for (int i = 0; i < HALF_BYTES; i++) begin
            pat_q[i] <= fold_case(cfg_wdata_i[i*BYTE_W +: BYTE_W]);
          end
        end
        REG_PAT_HI: begin
          for (int i = 0; i < HALF_BYTES; i++) begin
            pat_q[HALF_BYTES+i] <= fold_case(cfg_wdata_i[i*BYTE_W +: BYTE_W]);
          end
        end
        REG_PAT_LEN: begin
          len_q <= cfg_wdata_i[LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp the length to the window depth
  assign eff_len = (len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_q;

  // Window after shifting in the new byte, newest in entry 0
  always_comb begin
    win_new[0] = fold_case(s_axis_tdata[BYTE_W-1:0]);
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  // Parallel compare: pattern byte j against window entry len-1-j
  always_comb begin
    logic [WIN_IDX_W-1:0] idx;
    match_now = 1'b1;
    idx       = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (LEN_W'(j) < eff_len) begin
        idx = WIN_IDX_W'(eff_len - LEN_W'(j) - LEN_W'(1));
        if (win_new[idx] != pat_q[j]) begin
          match_now = 1'b0;
        end
      end
    end
  end

  // Start of a match ending at this byte, and whether it counts
  assign pos1      = {1'b0, cnt_q} + (CNT_W+1)'(1);
  assign start_now = pos1 - (CNT_W+1)'(eff_len);
  assign hit_now   = !hit_q && (eff_len != '0) && (pos1 >= (CNT_W+1)'(eff_len))
                     && match_now
                     && (start_now < (CNT_W+1)'(TEXT_MAX))
                     && (start_now <= (CNT_W+1)'(START_LIMIT));

  // Next search state and result
  always_comb begin
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    hit_start_d = hit_start_q;
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_start_d = out_start_q;
    if (accept) begin
      out_valid_d = s_axis_tlast;
      if (s_axis_tlast) begin
        out_found_d = hit_q || hit_now;
        if (hit_q) begin
          out_start_d = hit_start_q;
        end else if (hit_now) begin
          out_start_d = start_now[START_W-1:0];
        end else begin
          out_start_d = '0;
        end
        // Clear for the next text
        cnt_d       = '0;
        hit_d       = 1'b0;
        hit_start_d = '0;
      end else begin
        if (cnt_q < CNT_W'(CNT_MAX)) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (hit_now) begin
          hit_d       = 1'b1;
          hit_start_d = start_now[START_W-1:0];
        end
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      hit_start_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      hit_start_q <= hit_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Window and result payload; the counter guards stale window entries
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_q[k] <= win_new[k];
      end
    end
    out_found_q <= out_found_d;
    out_start_q <= out_start_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-START_W-1)'(0), out_start_q, out_found_q};

endmodule

`default_nettype wire

// ===== src/ciss_checker.sv =====
`default_nettype none

module ciss_checker
  import ciss_pkg::*;
(
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    s_axis_tvalid,
  input wire                    s_axis_tready,
  input wire                    s_axis_tlast,
  input wire                    m_axis_tvalid,
  input wire                    m_axis_tready,
  input wire [OUT_TDATA_W-1:0]  m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // No match reports a zero start
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[START_W:1] == '0)
    else $error("start set without a match");

  // Last byte yields a result next cycle
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("missing result after last byte");

  // Inner byte yields no result
  a_inner_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !m_axis_tvalid)
    else $error("result after a non-final byte");

  // Drop input ready while a result waits on the receiver
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

endmodule

bind case_insensitive_substring_search_top ciss_checker u_ciss_checker (.*);

`default_nettype wire

// ===== tb/tb_case_insensitive_substring_search_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_case_insensitive_substring_search_top;
  import ciss_pkg::*;

  localparam int N_DIRECTED  = 8;
  localparam int RANDOM_BYTES = 850;
  localparam int HOLD_CYCLES = 300;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic               found;
  } search_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_wr_en_i   = 1'b0;
  cfg_reg_e               cfg_index_i   = REG_PAT_LO;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [7:0] text_byte
  logic                   s_axis_tlast  = 1'b0; // is_final
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [0] match_found, [20:1] match_start

  // Shadow of the pattern registers
  logic [CFG_W-1:0] pat_lo  = '0;
  logic [CFG_W-1:0] pat_hi  = '0;
  logic [LEN_W-1:0] pat_len = '0;

  // Shadow of the per-text search state
  logic [BYTE_W-1:0]  window [PATTERN_MAX];
  int unsigned        seen_count = 0;
  logic               hit_seen   = 1'b0;
  logic [START_W-1:0] hit_pos    = '0;

  search_result_t pending_results [$];
  int             mismatches = 0;
  logic           steady     = 1'b0;
  logic           hold_req   = 1'b0;

  // Directed texts: empty pattern after reset, empty pattern with bytes set,
  // folded match, short text, zero pattern byte with extreme text bytes,
  // brackets that must not fold, first match kept, full-width pattern.
  string            dir_pat   [N_DIRECTED] = '{"", "q", "aB", "aB", "", "[", "a",
                                               "@123456789abcdez"};
  logic [LEN_W-1:0] dir_len   [N_DIRECTED] = '{5'd0, 5'd0, 5'd2, 5'd2, 5'd1, 5'd1, 5'd1,
                                               5'd16};
  string            dir_txt   [N_DIRECTED] = '{"a", "Q", "xAb", "A", "\001\377", "{[",
                                               "bAa", "@123456789ABCDEZ"};
  logic             dir_typed [N_DIRECTED] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                               1'b1};
  logic             dir_found [N_DIRECTED] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                               1'b1};
  logic [START_W-1:0] dir_start [N_DIRECTED] = '{20'd0, 20'd0, 20'd1, 20'd0, 20'd0, 20'd0,
                                                 20'd1, 20'd0};

  case_insensitive_substring_search_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    foreach (window[k]) window[k] = '0;
  end

  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // Swap the case of a letter half the time
  function automatic logic [BYTE_W-1:0] flip_case(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] low;
    low = c | 8'h20;
    if (low >= 8'h61 && low <= 8'h7A && $urandom_range(1) == 1) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  // Advance the search by one byte; on the last byte yield the result and clear
  function automatic void scan_byte(input logic [BYTE_W-1:0] raw, input logic last,
                                    output logic emit, output search_result_t res);
    int unsigned used;
    int unsigned first;
    logic        same;
    logic [2*CFG_W-1:0] pat;
    used = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    pat  = {pat_hi, pat_lo};
    for (int k = PATTERN_MAX - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = to_lower(raw);
    if (!hit_seen && used > 0 && seen_count + 1 >= used) begin
      same = 1'b1;
      for (int j = 0; j < used; j++) begin
        if (window[used-1-j] != to_lower(pat[8*j +: 8])) same = 1'b0;
      end
      first = seen_count + 1 - used;
      if (same && first < TEXT_MAX && first <= START_LIMIT) begin
        hit_seen = 1'b1;
        hit_pos  = first[START_W-1:0];
      end
    end
    if (seen_count < TEXT_MAX + PATTERN_MAX) seen_count++;
    emit      = last;
    res.found = hit_seen;
    res.start = hit_seen ? hit_pos : '0;
    if (last) begin
      foreach (window[k]) window[k] = '0;
      seen_count = 0;
      hit_seen   = 1'b0;
      hit_pos    = '0;
    end
  endfunction

  // Offer one byte, hold it until taken, then predict
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last, input logic typed,
                           input search_result_t given);
    logic           emit;
    search_result_t calc;
    while (!steady && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_byte(b, last, emit, calc);
    if (emit) pending_results.push_back(typed ? given : calc);
  endtask

  task automatic send_text(input logic [BYTE_W-1:0] text [$], input logic typed,
                           input search_result_t given);
    for (int i = 0; i < text.size(); i++) begin
      send_byte(text[i], i == text.size() - 1, typed, given);
    end
  endtask

  // Drain the block, then write all three registers
  task automatic load_pattern(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                              input logic [LEN_W-1:0] len);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= REG_PAT_LO;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_index_i <= REG_PAT_HI;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_index_i <= REG_PAT_LEN;
    cfg_wdata_i <= CFG_W'(len);
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    pat_lo  = lo;
    pat_hi  = hi;
    pat_len = len;
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        held     = HOLD_CYCLES;
      end
      if (held > 0) begin
        held--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 8);
      end
    end
  end

  // Compare each result taken with the oldest prediction
  always @(posedge clk_i) begin : check_results
    search_result_t         want;
    logic [OUT_TDATA_W-1:0] word;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected result: found=%0d start=%0d", m_axis_tdata[0],
                   m_axis_tdata[START_W:1]);
        end
      end else begin
        want = pending_results.pop_front();
        word = {{(OUT_TDATA_W-START_W-1){1'b0}}, want.start, want.found};
        if (m_axis_tdata !== word) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("result mismatch: found exp %0d got %0d, start exp %0d got %0d (%h)",
                     want.found, m_axis_tdata[0], want.start, m_axis_tdata[START_W:1],
                     m_axis_tdata);
          end
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [2*CFG_W-1:0] pat_bits;
    logic [BYTE_W-1:0]  text [$];
    logic [BYTE_W-1:0]  alpha [3];
    logic [BYTE_W-1:0]  c;
    logic [LEN_W-1:0]   len;
    search_result_t     given;
    string              s;
    int                 sent;
    int                 phase;
    int                 n;
    int                 at;
    int                 used;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed texts; the first runs on the reset registers
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (r != 0) begin
        pat_bits = '0;
        s = dir_pat[r];
        for (int i = 0; i < s.len(); i++) pat_bits[8*i +: 8] = s[i];
        load_pattern(pat_bits[CFG_W-1:0], pat_bits[2*CFG_W-1:CFG_W], dir_len[r]);
      end
      text.delete();
      s = dir_txt[r];
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      given.found = dir_found[r];
      given.start = dir_start[r];
      send_text(text, dir_typed[r], given);
    end

    // Random texts over a series of pattern settings
    sent  = 0;
    phase = 0;
    given = '0;
    while (sent < RANDOM_BYTES) begin
      foreach (alpha[k]) begin
        alpha[k] = ($urandom_range(1) == 1) ? 8'(8'h61 + $urandom_range(25))
                                            : 8'($urandom_range(1, 255));
      end
      for (int j = 0; j < PATTERN_MAX; j++) begin
        pat_bits[8*j +: 8] = flip_case(alpha[$urandom_range(2)]);
      end
      len = ((phase % 4) == 0) ? LEN_W'($urandom_range(0, 31)) : LEN_W'($urandom_range(1, 4));
      case (phase)
        1: begin
          pat_bits = '1;
          alpha[0] = 8'hFF;
          len      = 5'd16;
        end
        2: begin
          pat_bits = {$urandom, $urandom, $urandom, $urandom};
          len      = 5'd0;
        end
        3: begin
          pat_bits[CFG_W-1:0] = '0;
          len                 = 5'd3;
        end
        default: ;
      endcase
      load_pattern(pat_bits[CFG_W-1:0], pat_bits[2*CFG_W-1:CFG_W], len);
      steady = (phase == 6 || phase == 7);
      if (phase == 4) hold_req = 1'b1;
      used = (len > PATTERN_MAX) ? PATTERN_MAX : len;

      repeat (10) begin
        if (phase == 1) n = $urandom_range(16, 24);
        else n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
        text.delete();
        repeat (n) begin
          text.push_back(($urandom_range(99) < 85) ? flip_case(alpha[$urandom_range(2)])
                                                   : 8'($urandom_range(1, 255)));
        end
        // Plant the pattern in about half of the texts long enough to hold it
        if (used > 0 && n >= used && $urandom_range(1) == 1) begin
          at = $urandom_range(0, n - used);
          for (int j = 0; j < used; j++) begin
            c = pat_bits[8*j +: 8];
            text[at+j] = (c == 8'h00) ? 8'h01 : flip_case(c);
          end
        end
        send_text(text, 1'b0, given);
        sent += n;
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/ciss_pkg.sv
src/case_insensitive_substring_search_top.sv
src/ciss_checker.sv
tb/tb_case_insensitive_substring_search_top.sv
